/* rtl/ska_pkg.sv */
// ----------------------------------------------------------------------------
// ska_pkg
// Shared types and constants for the steno chord accumulator.
// ----------------------------------------------------------------------------
package ska_pkg;

  localparam int MAP_ENTRIES_DEF = 256;
  localparam int CHORD_KEYS_DEF  = 32;
  localparam int KEY_W           = 8;
  localparam int ENTRY_W         = 8;
  localparam int STROKE_W        = 32;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_OTHER   = 2'd3
  } ska_op_t;

  typedef struct packed {
    ska_op_t op;
    logic    injected;
  } ska_item_t;

  typedef struct packed {
    logic                consumed;
    logic                stroke_valid;
    logic [STROKE_W-1:0] stroke;
  } ska_res_t;

endpackage

/* rtl/ska_map.sv */
// ----------------------------------------------------------------------------
// ska_map
// Key map memory with per-entry valid bits; registered read port.
// ----------------------------------------------------------------------------
module ska_map
  import ska_pkg::*;
#(
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF,
  localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic               rd_ok,
  input  logic [AW-1:0]      rd_addr,
  output logic [ENTRY_W-1:0] rd_entry
);

  logic [ENTRY_W-1:0]     mem [MAP_ENTRIES];
  logic [MAP_ENTRIES-1:0] vld_r;
  logic [ENTRY_W-1:0]     rd_data_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= rd_ok && vld_r[rd_addr];
      end
    end
  end

  assign rd_entry = rd_vld_r ? rd_data_r : '0;

endmodule

/* rtl/ska_chord.sv */
// ----------------------------------------------------------------------------
// ska_chord
// Held-key and stroke state; builds one result per key event.
// ----------------------------------------------------------------------------
module ska_chord
  import ska_pkg::*;
#(
  parameter int CHORD_KEYS = CHORD_KEYS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  ska_item_t          item,
  input  logic [ENTRY_W-1:0] entry,
  output ska_res_t           res
);

  localparam int PAD_W = (CHORD_KEYS > STROKE_W) ? CHORD_KEYS : STROKE_W;

  logic [CHORD_KEYS-1:0] held_r, held_nxt;
  logic [CHORD_KEYS-1:0] stroke_r, stroke_nxt;
  logic [CHORD_KEYS-1:0] mask;
  logic [CHORD_KEYS-1:0] held_clr;
  logic [ENTRY_W-1:0]    bit_num;
  logic                  bit_ok;
  logic                  active;
  logic                  fire;
  logic [PAD_W-1:0]      stroke_pad;

  assign bit_num = entry - ENTRY_W'(1);
  assign bit_ok  = bit_num < ENTRY_W'(CHORD_KEYS);
  assign active  = ((item.op == OP_PRESS) || (item.op == OP_RELEASE)) &&
                   !item.injected && (entry != '0);

  always_comb begin
    for (int i = 0; i < CHORD_KEYS; i++) begin
      mask[i] = bit_ok && (bit_num == ENTRY_W'(i));
    end
  end

  assign held_clr   = held_r & ~mask;
  assign fire       = active && (item.op == OP_RELEASE) &&
                      (held_r != '0) && (held_clr == '0);
  assign stroke_pad = PAD_W'(stroke_r);

  always_comb begin
    held_nxt   = held_r;
    stroke_nxt = stroke_r;
    if (active) begin
      if (item.op == OP_PRESS) begin
        held_nxt   = held_r | mask;
        stroke_nxt = stroke_r | held_nxt;
      end else begin
        held_nxt = held_clr;
        if (fire) begin
          stroke_nxt = '0;
        end
      end
    end
  end

  always_comb begin
    res.consumed     = active;
    res.stroke_valid = fire;
    res.stroke       = fire ? stroke_pad[STROKE_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      stroke_r <= '0;
    end else if (advance) begin
      held_r   <= held_nxt;
      stroke_r <= stroke_nxt;
    end
  end

endmodule

/* rtl/steno_chord_accumulator.sv */
// ----------------------------------------------------------------------------
// steno_chord_accumulator
// Collects mapped key presses into a chord and emits it on full release.
//
//   channel | dir | tdata                          | tuser
//   in_     | in  | key_code[7:0], map_value[15:8] | opcode[1:0], injected[2]
//   out_    | out | stroke[31:0]                   | consumed[0], stroke_valid[1]
//
// One item per cycle unless the output stalls; each item passes the input stage, then the result register.
// First, key map read (registered memory port) into the input stage.
// Then chord state update and result register load.
// Reset clears the map valid bits and chord state; no clearing pass.
// Output stall holds the input stage; in_tready drops only when both are full.
// ----------------------------------------------------------------------------
module steno_chord_accumulator
  import ska_pkg::*;
#(
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF,
  parameter int CHORD_KEYS  = CHORD_KEYS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // key_code[7:0], map_value[15:8]
  input  logic [2:0]  in_tuser,   // opcode[1:0], injected[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // stroke[31:0]
  output logic [1:0]  out_tuser   // consumed[0], stroke_valid[1]
);

  localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

  logic               in_accept;
  logic               advance;
  ska_op_t            in_op;
  logic [KEY_W-1:0]   in_key;
  logic [ENTRY_W-1:0] in_value;
  logic               in_map;
  logic [ENTRY_W-1:0] entry;

  logic               s1_valid_r;
  ska_item_t          s1_item_r;
  ska_res_t           res;
  logic               out_valid_r;
  ska_res_t           out_res_r;

  assign in_op     = ska_op_t'(in_tuser[1:0]);
  assign in_key    = in_tdata[7:0];
  assign in_value  = in_tdata[15:8];
  assign in_map    = {1'b0, in_key} < (KEY_W + 1)'(MAP_ENTRIES);

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  ska_map #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_accept && (in_op == OP_WRITE) && in_map),
    .wr_addr (in_key[AW-1:0]),
    .wr_data (in_value),
    .rd_en   (in_accept),
    .rd_ok   (in_map),
    .rd_addr (in_key[AW-1:0]),
    .rd_entry(entry)
  );

  ska_chord #(
    .CHORD_KEYS(CHORD_KEYS)
  ) u_chord (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(advance && s1_valid_r),
    .item   (s1_item_r),
    .entry  (entry),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.op       <= in_op;
      s1_item_r.injected <= in_tuser[2];
    end
    if (advance && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.stroke;
  assign out_tuser  = {out_res_r.stroke_valid, out_res_r.consumed};

  a_valid_needs_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("stroke emitted on a passed-on event");

  a_stroke_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata == '0)
    else $error("stroke nonzero without stroke_valid");

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while output register empty");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage lost an item under stall");

endmodule
